### design/tsc_pkg.sv
// Shared types and codes for the TFTP transfer controller.
// No dependencies; imported by tsc_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  // received opcodes
  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // transmitted opcodes
  localparam logic [2:0] SOP_NONE  = 3'd0;
  localparam logic [2:0] SOP_DATA  = 3'd3;
  localparam logic [2:0] SOP_ACK   = 3'd4;
  localparam logic [2:0] SOP_ERROR = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
  localparam logic [2:0] ERR_ACCESS    = 3'd2;
  localparam logic [2:0] ERR_ILLEGAL   = 3'd4;

  // file actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_OPEN_RD = 3'd1;
  localparam logic [2:0] ACT_OPEN_WR = 3'd2;
  localparam logic [2:0] ACT_READ    = 3'd3;
  localparam logic [2:0] ACT_APPEND  = 3'd4;

  localparam logic [7:0] LIMIT_RESET = 8'd10;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_NEW,
    MODE_RESEND
  } tsc_mode_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] opcode_in;
    logic [15:0] block_in;
    logic [9:0]  payload_length;
    logic        file_ok;
    logic [9:0]  file_bytes;
  } tsc_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [2:0]  send_opcode;
    logic [15:0] send_block;
    logic [2:0]  send_error;
    logic [9:0]  send_length;
    logic [24:0] file_offset;
    logic [2:0]  file_action;
    logic        session_end;
  } tsc_result_t;

  typedef struct packed {
    logic        active;
    logic [15:0] exp_blk;
    logic [7:0]  to_cnt;
    logic        complete;
    logic        err_pend;
    logic        fh_open;
    logic [2:0]  last_op;
    logic [15:0] last_blk;
    logic [2:0]  last_err;
    logic [9:0]  last_len;
  } tsc_state_t;

endpackage

`default_nettype wire

### design/tsc_step.sv
// Session step logic: one item plus current session state gives the
// result and the next session state. Purely combinational. Uses tsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsc_step #(
  parameter int BLOCK_BYTES = 512
) (
  input  tsc_pkg::tsc_item_t   item,
  input  tsc_pkg::tsc_state_t  st,
  input  logic [7:0]           limit,
  output tsc_pkg::tsc_state_t  st_nxt,
  output tsc_pkg::tsc_result_t res
);
  import tsc_pkg::*;

  localparam logic [16:0] BB = 17'(BLOCK_BYTES);

  tsc_state_t  s;
  tsc_mode_t   mode;
  logic [2:0]  sop;
  logic [2:0]  serr;
  logic [15:0] sblk;
  logic [9:0]  slen;
  logic [2:0]  act;
  logic [24:0] offset;
  logic        fin;
  logic [7:0]  lim;
  logic [9:0]  flen_clamp;
  logic        short_payload;
  logic [15:0] exp_inc;
  logic [15:0] blk_m1;
  logic [32:0] prod;

  // file_bytes above a block is sent as a full block
  assign flen_clamp    = ({7'd0, item.file_bytes} > BB) ? BB[9:0] : item.file_bytes;
  assign short_payload = {7'd0, item.payload_length} < BB;
  assign lim           = (limit == 8'd0) ? 8'd1 : limit;
  assign exp_inc       = st.exp_blk + 16'd1;
  assign blk_m1        = st.exp_blk;   // (exp_blk + 1) - 1
  assign prod          = 33'(blk_m1) * 33'(BB);

  always_comb begin
    s      = st;
    mode   = MODE_NONE;
    sop    = SOP_NONE;
    serr   = 3'd0;
    sblk   = 16'd0;
    slen   = 10'd0;
    act    = ACT_NONE;
    offset = 25'd0;
    fin    = 1'b0;

    if (item.req_type) begin
      if (s.active) begin
        if (s.to_cnt != COUNT_MAX) s.to_cnt = s.to_cnt + 8'd1;
        if (s.to_cnt >= lim) fin = 1'b1;
        else mode = MODE_RESEND;
      end
    end else begin
      if (!s.active) begin
        s        = '0;
        s.active = 1'b1;
      end else begin
        s.to_cnt = 8'd0;
      end
      unique case (item.opcode_in)
        OP_RRQ: begin
          s.fh_open = 1'b0;
          act       = ACT_OPEN_RD;
          mode      = MODE_NEW;
          if (!item.file_ok) begin
            sop = SOP_ERROR; serr = ERR_NOT_FOUND; s.err_pend = 1'b1;
          end else begin
            s.fh_open = 1'b1;
            s.exp_blk = 16'd1;
            sop = SOP_DATA; sblk = 16'd1; slen = flen_clamp;
          end
        end
        OP_WRQ: begin
          if (!s.fh_open) begin
            act       = ACT_OPEN_WR;
            s.fh_open = item.file_ok;
          end
          mode = MODE_NEW;
          if (!s.fh_open) begin
            sop = SOP_ERROR; serr = ERR_NOT_FOUND; s.err_pend = 1'b1;
          end else begin
            sop = SOP_ACK; sblk = s.exp_blk;
            s.exp_blk = s.exp_blk + 16'd1;
          end
        end
        OP_DATA: begin
          if (item.block_in == s.exp_blk) begin
            act  = ACT_APPEND;
            mode = MODE_NEW;
            if (!item.file_ok) begin
              sop = SOP_ERROR; serr = ERR_ACCESS; s.err_pend = 1'b1;
            end else begin
              sop = SOP_ACK; sblk = s.exp_blk;
              s.exp_blk = s.exp_blk + 16'd1;
            end
          end else begin
            mode = MODE_RESEND;
          end
          if (short_payload) begin
            s.fh_open  = 1'b0;
            s.complete = 1'b1;
          end
        end
        OP_ACK: begin
          if (item.block_in == s.exp_blk) begin
            // a fresh session has exp_blk 0, so exp_inc stays valid here
            s.exp_blk = exp_inc;
            s.to_cnt  = 8'd0;
            act       = s.fh_open ? ACT_READ : ACT_OPEN_RD;
            if (!item.file_ok) begin
              mode = MODE_NEW;
              sop = SOP_ERROR; serr = ERR_ACCESS; s.err_pend = 1'b1;
            end else begin
              s.fh_open = 1'b1;
              offset    = prod[24:0];
              if (item.file_bytes == 10'd0) begin
                s.complete = 1'b1;
                fin        = 1'b1;
              end else begin
                mode = MODE_NEW;
                sop = SOP_DATA; sblk = exp_inc; slen = flen_clamp;
              end
            end
          end else begin
            mode = MODE_RESEND;
          end
        end
        OP_ERROR: fin = 1'b1;
        default: begin
          mode = MODE_NEW;
          sop = SOP_ERROR; serr = ERR_ILLEGAL; s.err_pend = 1'b1;
        end
      endcase
    end

    unique case (mode)
      MODE_RESEND: begin
        if (s.last_op != SOP_NONE) begin
          sop = s.last_op; sblk = s.last_blk; serr = s.last_err; slen = s.last_len;
        end else begin
          mode = MODE_NONE;
        end
      end
      MODE_NEW: begin
        s.last_op = sop; s.last_blk = sblk; s.last_err = serr; s.last_len = slen;
      end
      default: ;
    endcase

    if (mode != MODE_NONE && (s.complete || s.err_pend)) fin = 1'b1;
    if (fin) s = '0;

    st_nxt          = s;
    res.send_valid  = (mode != MODE_NONE);
    res.send_opcode = sop;
    res.send_block  = sblk;
    res.send_error  = serr;
    res.send_length = slen;
    res.file_offset = offset;
    res.file_action = act;
    res.session_end = fin;
  end

endmodule

`default_nettype wire

### design/tftp_server_transfer_control_unit.sv
// TFTP server transfer controller, top level: input register, session
// state, result register. Depends on tsc_pkg and tsc_step.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | handshake          | carries
//  --------+--------------------+-------------------------------------------
//  in_     | in_valid/in_stall  | packet or timeout tick, file status
//  out_    | out_valid/out_stall| packet to send, file action, session end
//  cfg_    | cfg_valid/cfg_ready| tick limit (always ready)
//
//  Input register, then result register; one item per cycle unless stalled.
//  The rate is set by the session state register, updated once per item
//  as the item leaves the input register for the result register.
//  Reset (rst_n low, synchronous) clears the session and sets the limit to 10.
//  A stalled result register holds the input register and raises in_stall.

module tftp_server_transfer_control_unit #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_opcode_in,
  input  logic [15:0] in_block_in,
  input  logic [9:0]  in_payload_length,
  input  logic        in_file_ok,
  input  logic [9:0]  in_file_bytes,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_valid,
  output logic [2:0]  out_send_opcode,
  output logic [15:0] out_send_block,
  output logic [2:0]  out_send_error,
  output logic [9:0]  out_send_length,
  output logic [24:0] out_file_offset,
  output logic [2:0]  out_file_action,
  output logic        out_session_end,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_tick_limit
);
  import tsc_pkg::*;

  logic        in_acc;
  logic        out_free;
  logic        adv;

  logic        s1_valid_r, s1_valid_nxt;
  tsc_item_t   s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  tsc_result_t out_res_r;
  tsc_state_t  state_r;
  tsc_state_t  state_nxt;
  tsc_result_t res_nxt;
  logic [7:0]  limit_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  tsc_step #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_step (
    .item   (s1_item_r),
    .st     (state_r),
    .limit  (limit_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      limit_r     <= LIMIT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) state_r <= state_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_tick_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{req_type:       in_req_type,
                     opcode_in:      in_opcode_in,
                     block_in:       in_block_in,
                     payload_length: in_payload_length,
                     file_ok:        in_file_ok,
                     file_bytes:     in_file_bytes};
    end
    if (adv) out_res_r <= res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_send_valid  = out_res_r.send_valid;
  assign out_send_opcode = out_res_r.send_opcode;
  assign out_send_block  = out_res_r.send_block;
  assign out_send_error  = out_res_r.send_error;
  assign out_send_length = out_res_r.send_length;
  assign out_file_offset = out_res_r.file_offset;
  assign out_file_action = out_res_r.file_action;
  assign out_session_end = out_res_r.session_end;

`ifndef ASSERT_OFF
  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.session_end |=> !state_r.active)
    else $error("session still active after session_end");

  a_idle_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.active |-> state_r.exp_blk == 16'd0 && state_r.last_op == SOP_NONE)
    else $error("idle state not cleared");

  a_send_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.send_valid |->
      out_res_r.send_opcode == SOP_DATA || out_res_r.send_opcode == SOP_ACK ||
      out_res_r.send_opcode == SOP_ERROR)
    else $error("bad opcode on a sent packet");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("session state changed without an item");
`endif

endmodule

`default_nettype wire
